[design/svdbs_pkg.sv]
// Package with shared types and constants of the SVD back-substitution block.
package svdbs_pkg;

	localparam int MaxRowsDefault = 16;
	localparam int MaxColsDefault = 16;
	localparam int OutLimit = 16;
	localparam int CfgWidth = 5;

	localparam logic [2:0] ReqLoadU = 3'd0;
	localparam logic [2:0] ReqLoadW = 3'd1;
	localparam logic [2:0] ReqLoadV = 3'd2;
	localparam logic [2:0] ReqLoadB = 3'd3;
	localparam logic [2:0] ReqCompute = 3'd4;

	localparam logic CfgRowCount = 1'b0;
	localparam logic CfgColCount = 1'b1;

	typedef struct packed {
		logic [2:0] req_type;
		logic [3:0] row_index;
		logic [3:0] col_index;
		logic signed [31:0] load_value;
	} in_item_t;

	typedef struct packed {
		logic [3:0] coef_index;
		logic signed [31:0] coef_value;
		logic last_coef;
		logic saturated;
	} out_item_t;

	// Datapath operations issued by the controller.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_CLEAR,
		OP_MAC_U,
		OP_MAC_V,
		OP_DIV_START,
		OP_PROJ_ZERO,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic [3:0] col;
		logic [3:0] idx;
		logic last;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic w_zero;
	} dp_status_t;

	// Saturating signed 64-bit add.
	function automatic logic [64:0] sat_add64(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		begin
			s = {a[63], a} + {b[63], b};
			if (s[64] != s[63])
				sat_add64 = s[64] ? {1'b1, 1'b1, 63'd0} : {1'b1, 1'b0, {63{1'b1}}};
			else
				sat_add64 = {1'b0, s[63:0]};
		end
	endfunction

endpackage

[design/svdbs_ram.sv]
// Generic single-port-write RAM with registered read.
module svdbs_ram #(
	parameter int Width = 32,
	parameter int Depth = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[design/svdbs_div.sv]
// Restoring divider: 64-bit signed dividend by 32-bit signed divisor, saturated Q16.16.
module svdbs_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [63:0] num,
	input logic signed [31:0] den,
	output logic done,
	output logic signed [31:0] quot,
	output logic clip
);
	logic [63:0] rem_q;
	logic [63:0] q_q;
	logic [31:0] d_q;
	logic neg_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic [64:0] trial;
	logic [64:0] shifted;

	// One quotient bit per cycle.
	assign shifted = {rem_q, q_q[63]};
	assign trial = shifted - {33'd0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd0;
				rem_q <= '0;
				q_q <= num[63] ? 64'd0 - num : num;
				d_q <= den[31] ? 32'd0 - den : den;
				neg_q <= num[63] ^ den[31];
			end else if (busy_q) begin
				if (!trial[64]) begin
					rem_q <= trial[63:0];
				end else begin
					rem_q <= shifted[63:0];
				end
				q_q <= {q_q[62:0], ~trial[64]};
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// Sign and saturation of the finished quotient.
	always_comb begin
		clip = 1'b0;
		if (neg_q) begin
			if (q_q > 64'h8000_0000) begin
				clip = 1'b1;
				quot = 32'sh8000_0000;
			end else begin
				quot = 32'(64'd0 - q_q);
			end
		end else if (q_q > 64'h7FFF_FFFF) begin
			clip = 1'b1;
			quot = 32'sh7FFF_FFFF;
		end else begin
			quot = q_q[31:0];
		end
	end
endmodule

[design/svdbs_datapath.sv]
// Datapath: stores, multiply-accumulate, divider and result register.
module svdbs_datapath #(
	parameter int MaxRows = 16,
	parameter int MaxCols = 16
) (
	input logic clk,
	input logic arst_n,
	input svdbs_pkg::in_item_t in_item,
	input logic load_en,
	input svdbs_pkg::dp_cmd_t cmd,
	output svdbs_pkg::dp_status_t status,
	output svdbs_pkg::out_item_t result
);
	import svdbs_pkg::*;

	localparam int RowW = (MaxRows > 1) ? $clog2(MaxRows) : 1;
	localparam int ColW = (MaxCols > 1) ? $clog2(MaxCols) : 1;
	localparam int UDepth = MaxRows * MaxCols;
	localparam int VDepth = MaxCols * MaxCols;
	localparam int UAw = $clog2(UDepth) > 0 ? $clog2(UDepth) : 1;
	localparam int VAw = $clog2(VDepth) > 0 ? $clog2(VDepth) : 1;

	logic [UAw-1:0] u_waddr, u_raddr;
	logic [VAw-1:0] v_waddr, v_raddr;
	logic [31:0] u_rd, v_rd;
	logic u_we, v_we;
	logic in_range_r, in_range_c, in_range_rw;
	logic signed [31:0] w_q [MaxCols];
	logic signed [31:0] b_q [MaxRows];
	logic signed [31:0] p_q [MaxCols];
	logic signed [31:0] vec_s1;
	logic [1:0] mac_s1;
	logic [1:0] mac_s2;
	logic signed [63:0] prod_s2;
	logic signed [63:0] acc_q;
	logic [64:0] sum;
	logic clip_q;
	logic proj_clip_q;
	logic div_start;
	logic div_done;
	logic signed [31:0] div_quot;
	logic div_clip;
	logic [3:0] div_col_q;
	logic signed [47:0] shr;
	logic signed [31:0] narrow;
	logic narrow_clip;

	assign in_range_r = 32'(in_item.row_index) < MaxRows;
	assign in_range_rw = 32'(in_item.row_index) < MaxCols;
	assign in_range_c = 32'(in_item.col_index) < MaxCols;
	assign u_we = load_en && in_item.req_type == ReqLoadU && in_range_r && in_range_c;
	assign v_we = load_en && in_item.req_type == ReqLoadV && in_range_rw && in_range_c;
	assign u_waddr = UAw'(32'(in_item.row_index) * MaxCols + 32'(in_item.col_index));
	assign v_waddr = VAw'(32'(in_item.row_index) * MaxCols + 32'(in_item.col_index));
	assign u_raddr = UAw'(32'(cmd.idx) * MaxCols + 32'(cmd.col));
	assign v_raddr = VAw'(32'(cmd.col) * MaxCols + 32'(cmd.idx));

	svdbs_ram #(.Width(32), .Depth(UDepth)) u_ram (
		.clk(clk), .we(u_we), .waddr(u_waddr), .wdata(in_item.load_value),
		.raddr(u_raddr), .rdata(u_rd)
	);
	svdbs_ram #(.Width(32), .Depth(VDepth)) v_ram (
		.clk(clk), .we(v_we), .waddr(v_waddr), .wdata(in_item.load_value),
		.raddr(v_raddr), .rdata(v_rd)
	);

	// Vector stores and the projection register file.
	always_ff @(posedge clk) begin
		if (load_en && in_item.req_type == ReqLoadW && in_range_rw) begin
			w_q[in_item.row_index[ColW-1:0]] <= in_item.load_value;
		end
		if (load_en && in_item.req_type == ReqLoadB && in_range_r) begin
			b_q[in_item.row_index[RowW-1:0]] <= in_item.load_value;
		end
		if (cmd.op == OP_PROJ_ZERO) begin
			p_q[cmd.col[ColW-1:0]] <= '0;
		end
		if (div_done) begin
			p_q[div_col_q[ColW-1:0]] <= div_quot;
		end
	end

	assign status.w_zero = w_q[cmd.col[ColW-1:0]] == 32'sd0;
	assign status.div_done = div_done;

	// Stage 1: RAM read plus vector operand; stage 2: product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1 <= '0;
			mac_s2 <= '0;
		end else begin
			mac_s1 <= {cmd.op == OP_MAC_V, cmd.op == OP_MAC_U};
			mac_s2 <= mac_s1;
		end
	end

	always_ff @(posedge clk) begin
		vec_s1 <= (cmd.op == OP_MAC_V) ? p_q[cmd.idx[ColW-1:0]] : b_q[cmd.idx[RowW-1:0]];
		prod_s2 <= (mac_s1[1] ? $signed(v_rd) : $signed(u_rd)) * vec_s1;
	end

	assign sum = sat_add64(acc_q, prod_s2);

	// Accumulator and clip flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proj_clip_q <= 1'b0;
			clip_q <= 1'b0;
		end else begin
			if (cmd.op == OP_CLEAR) begin
				if (cmd.last) begin
					proj_clip_q <= 1'b0;
				end
				clip_q <= 1'b0;
			end else if (mac_s2 != 2'b00 && sum[64]) begin
				clip_q <= 1'b1;
			end
			if (div_done && div_clip) begin
				proj_clip_q <= 1'b1;
			end
			if (cmd.op == OP_DIV_START && clip_q) begin
				proj_clip_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_CLEAR) begin
			acc_q <= '0;
		end else if (mac_s2 != 2'b00) begin
			acc_q <= sum[63:0];
		end
		if (cmd.op == OP_DIV_START) begin
			div_col_q <= cmd.col;
		end
	end

	assign div_start = cmd.op == OP_DIV_START;

	svdbs_div div_i (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(acc_q),
		.den(w_q[cmd.col[ColW-1:0]]), .done(div_done), .quot(div_quot), .clip(div_clip)
	);

	// Narrowing by an arithmetic shift rounds toward minus infinity.
	assign shr = 48'(acc_q >>> 16);
	always_comb begin
		narrow_clip = 1'b0;
		if (shr > 48'sh0000_7FFF_FFFF) begin
			narrow = 32'sh7FFF_FFFF;
			narrow_clip = 1'b1;
		end else if (shr < -48'sh0000_8000_0000) begin
			narrow = 32'sh8000_0000;
			narrow_clip = 1'b1;
		end else begin
			narrow = shr[31:0];
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT) begin
			result.coef_index <= cmd.col;
			result.coef_value <= narrow;
			result.last_coef <= cmd.last;
			result.saturated <= proj_clip_q | clip_q | narrow_clip;
		end
	end
endmodule

[design/svdbs_ctrl.sv]
// Controller: sequences projection and coefficient passes and the output handshake.
module svdbs_ctrl #(
	parameter int MaxRows = 16,
	parameter int MaxCols = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [0:0] cfg_sel,
	input logic [svdbs_pkg::CfgWidth-1:0] cfg_data,
	input logic start,
	input svdbs_pkg::dp_status_t status,
	input logic out_stall,
	output logic busy,
	output logic out_valid,
	output svdbs_pkg::dp_cmd_t cmd
);
	import svdbs_pkg::*;

	localparam int ColLim = (MaxCols < OutLimit) ? MaxCols : OutLimit;

	typedef enum logic [2:0] {
		S_IDLE, S_PCLR, S_PMAC, S_PDIV, S_CCLR, S_CMAC, S_EMIT, S_WAIT
	} state_t;

	state_t state_q;
	logic [4:0] rows_q, cols_q;
	logic [4:0] m, n;
	logic [3:0] col_q, idx_q;
	logic [1:0] drain_q;
	logic out_valid_q;

	// Clamp the register counts to the supported range.
	always_comb begin
		m = (rows_q == 5'd0) ? 5'd1 : (32'(rows_q) > MaxRows ? 5'(MaxRows) : rows_q);
		n = (cols_q == 5'd0) ? 5'd1 : (32'(cols_q) > ColLim ? 5'(ColLim) : cols_q);
	end

	assign busy = state_q != S_IDLE || out_valid_q;
	assign out_valid = out_valid_q;

	// Command to the datapath.
	always_comb begin
		cmd.op = OP_NONE;
		cmd.col = col_q;
		cmd.idx = idx_q;
		cmd.last = 1'b0;
		case (state_q)
			S_PCLR: begin
				cmd.op = status.w_zero ? OP_PROJ_ZERO : OP_CLEAR;
			end
			S_PMAC: begin
				if (drain_q == 2'd0) cmd.op = OP_MAC_U;
			end
			S_PDIV: begin
				if (drain_q == 2'd3) cmd.op = OP_DIV_START;
			end
			S_CCLR: begin
				cmd.op = OP_CLEAR;
			end
			S_CMAC: begin
				if (drain_q == 2'd0) cmd.op = OP_MAC_V;
			end
			S_EMIT: begin
				cmd.op = OP_EMIT;
				cmd.last = 5'(col_q) + 5'd1 == n;
			end
			default: begin
				cmd.op = (state_q == S_IDLE && start) ? OP_CLEAR : OP_NONE;
				cmd.last = 1'b1;
			end
		endcase
	end

	// State register, counters and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rows_q <= 5'd16;
			cols_q <= 5'd16;
			col_q <= '0;
			idx_q <= '0;
			drain_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_sel == CfgRowCount) rows_q <= cfg_data;
			if (cfg_we && cfg_sel == CfgColCount) cols_q <= cfg_data;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						col_q <= '0;
						idx_q <= '0;
						state_q <= S_PCLR;
					end
				end
				S_PCLR: begin
					idx_q <= '0;
					drain_q <= '0;
					state_q <= status.w_zero ? S_PDIV : S_PMAC;
					if (status.w_zero) drain_q <= 2'd1;
				end
				S_PMAC: begin
					if (drain_q != 2'd0) begin
						drain_q <= drain_q + 2'd1;
						if (drain_q == 2'd2) drain_q <= 2'd3;
						if (drain_q == 2'd3) begin
							drain_q <= 2'd3;
							state_q <= S_PDIV;
						end
					end else if (5'(idx_q) + 5'd1 == m) begin
						drain_q <= 2'd1;
					end else begin
						idx_q <= idx_q + 4'd1;
					end
				end
				S_PDIV: begin
					// drain 3 means the divider was started; 1 means skipped.
					if (drain_q == 2'd3) begin
						drain_q <= 2'd2;
					end else if (drain_q == 2'd1 || status.div_done) begin
						if (5'(col_q) + 5'd1 == n) begin
							col_q <= '0;
							state_q <= S_CCLR;
						end else begin
							col_q <= col_q + 4'd1;
							state_q <= S_PCLR;
						end
					end
				end
				S_CCLR: begin
					idx_q <= '0;
					drain_q <= '0;
					state_q <= S_CMAC;
				end
				S_CMAC: begin
					if (drain_q != 2'd0) begin
						drain_q <= drain_q + 2'd1;
						if (drain_q == 2'd3) state_q <= S_WAIT;
					end else if (5'(idx_q) + 5'd1 == n) begin
						drain_q <= 2'd1;
					end else begin
						idx_q <= idx_q + 4'd1;
					end
				end
				S_WAIT: begin
					if (!out_valid_q || !out_stall) state_q <= S_EMIT;
				end
				S_EMIT: begin
					out_valid_q <= 1'b1;
					if (5'(col_q) + 5'd1 == n) begin
						state_q <= S_IDLE;
					end else begin
						col_q <= col_q + 4'd1;
						state_q <= S_CCLR;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[design/svd_back_substitution_top.sv]
// Top level of the SVD back-substitution block.
// Load items are accepted back to back while no compute runs.
// A compute item is paced by the shared multiply-accumulate unit and the bit-serial divider,
// which the projection of a column with a zero singular value skips, and by any output stalls.
// The next item is accepted once the last coefficient has been taken.
// Reset clears control state and the count registers to 16; stores are undefined until written.
module svd_back_substitution_top #(
	parameter int MaxRows = svdbs_pkg::MaxRowsDefault,
	parameter int MaxCols = svdbs_pkg::MaxColsDefault
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input svdbs_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output svdbs_pkg::out_item_t out_item,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [svdbs_pkg::CfgWidth-1:0] cfg_data
);
	import svdbs_pkg::*;

	logic busy;
	logic accept;
	dp_cmd_t cmd;
	dp_status_t status;

	assign in_stall = busy;
	assign accept = in_valid && !busy;

	svdbs_ctrl #(.MaxRows(MaxRows), .MaxCols(MaxCols)) ctrl_i (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_sel(cfg_index),
		.cfg_data(cfg_data), .start(accept && in_item.req_type == ReqCompute),
		.status(status), .out_stall(out_stall), .busy(busy),
		.out_valid(out_valid), .cmd(cmd)
	);

	svdbs_datapath #(.MaxRows(MaxRows), .MaxCols(MaxCols)) dp_i (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .load_en(accept),
		.cmd(cmd), .status(status), .result(out_item)
	);
endmodule

[tb/svd_bs_checker.sv]
// Checker for the SVD back-substitution block: predicts coefficients and compares them.
module svd_bs_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input svdbs_pkg::in_item_t in_item,
	input logic out_valid,
	input logic out_stall,
	input svdbs_pkg::out_item_t out_item,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [svdbs_pkg::CfgWidth-1:0] cfg_data,
	output int errors,
	output int pending,
	output int coefs_seen,
	output int sat_seen
);
	import svdbs_pkg::*;

	logic signed [31:0] u_store [16][16];
	logic signed [31:0] w_store [16];
	logic signed [31:0] v_store [16][16];
	logic signed [31:0] b_store [16];
	logic signed [31:0] proj_store [16];
	logic [CfgWidth-1:0] rows_cfg;
	logic [CfgWidth-1:0] cols_cfg;
	out_item_t coef_q [$];
	int err_cnt;
	int coef_cnt;
	int sat_cnt;

	// Saturating signed 64-bit sum; sets clip when the bounds are hit.
	function automatic longint sat_sum(longint a, longint b, inout bit clip);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			clip = 1'b1;
			return s[64] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
		end
		return s[63:0];
	endfunction

	function automatic logic signed [31:0] clip32(longint x, inout bit clip);
		if (x > 64'sd2147483647) begin
			clip = 1'b1;
			return 32'h7fff_ffff;
		end
		if (x < -64'sd2147483648) begin
			clip = 1'b1;
			return 32'h8000_0000;
		end
		return x[31:0];
	endfunction

	// Q32.32 over Q16.16, truncated toward zero and saturated.
	function automatic logic signed [31:0] proj_div(longint num, logic signed [31:0] d,
			inout bit clip);
		longint unsigned nm, dm, q;
		longint r;
		bit neg;
		nm = num;
		if (num < 0)
			nm = 64'd0 - nm;
		dm = longint'(d);
		if (d < 0)
			dm = 64'd0 - dm;
		q = nm / dm;
		neg = (num < 0) != (d < 0);
		if (neg) begin
			if (q > 64'd2147483648) begin
				clip = 1'b1;
				return 32'h8000_0000;
			end
			r = -longint'(q);
			return r[31:0];
		end
		if (q > 64'd2147483647) begin
			clip = 1'b1;
			return 32'h7fff_ffff;
		end
		return q[31:0];
	endfunction

	// Q32.32 to Q16.16, rounding toward minus infinity, saturated.
	function automatic logic signed [31:0] narrow(longint acc, inout bit clip);
		longint unsigned mg;
		longint r;
		if (acc >= 0) begin
			r = acc >>> 16;
		end else begin
			mg = acc;
			mg = 64'd0 - mg;
			r = -longint'((mg + 64'd65535) >> 16);
		end
		return clip32(r, clip);
	endfunction

	// Solve for the coefficients with the current stores and counts.
	task automatic solve_coefs();
		int m, n;
		bit pclip, cl;
		longint acc;
		out_item_t it;
		m = (rows_cfg == 0) ? 1 : ((rows_cfg > 16) ? 16 : int'(rows_cfg));
		n = (cols_cfg == 0) ? 1 : ((cols_cfg > 16) ? 16 : int'(cols_cfg));
		pclip = 1'b0;
		for (int i = 0; i < n; i++) begin
			if (w_store[i] != 0) begin
				acc = 0;
				for (int j = 0; j < m; j++)
					acc = sat_sum(acc, longint'(u_store[j][i]) * longint'(b_store[j]), pclip);
				proj_store[i] = proj_div(acc, w_store[i], pclip);
			end else begin
				proj_store[i] = '0;
			end
		end
		for (int i = 0; i < n; i++) begin
			cl = pclip;
			acc = 0;
			for (int j = 0; j < n; j++)
				acc = sat_sum(acc, longint'(v_store[i][j]) * longint'(proj_store[j]), cl);
			it.coef_value = narrow(acc, cl);
			it.coef_index = i[3:0];
			it.last_coef = (i + 1 == n);
			it.saturated = cl;
			coef_q.push_back(it);
		end
	endtask

	task automatic report(string what, out_item_t exp_it, out_item_t got);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%s: expected idx %0d val %h last %b sat %b, got idx %0d val %h last %b sat %b",
				what, exp_it.coef_index, exp_it.coef_value, exp_it.last_coef,
				exp_it.saturated, got.coef_index, got.coef_value, got.last_coef,
				got.saturated);
	endtask

	// Track configuration, loads and computes; check each accepted coefficient.
	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_it;
		if (!arst_n) begin
			rows_cfg = 5'd16;
			cols_cfg = 5'd16;
			for (int i = 0; i < 16; i++) begin
				w_store[i] = '0;
				b_store[i] = '0;
				proj_store[i] = '0;
				for (int j = 0; j < 16; j++) begin
					u_store[i][j] = '0;
					v_store[i][j] = '0;
				end
			end
			coef_q.delete();
			err_cnt = 0;
			coef_cnt = 0;
			sat_cnt = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CfgRowCount)
					rows_cfg = cfg_data;
				else
					cols_cfg = cfg_data;
			end
			if (in_valid && !in_stall) begin
				case (in_item.req_type)
					ReqLoadU: u_store[in_item.row_index][in_item.col_index] = in_item.load_value;
					ReqLoadW: w_store[in_item.row_index] = in_item.load_value;
					ReqLoadV: v_store[in_item.row_index][in_item.col_index] = in_item.load_value;
					ReqLoadB: b_store[in_item.row_index] = in_item.load_value;
					ReqCompute: solve_coefs();
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				coef_cnt++;
				if (out_item.saturated)
					sat_cnt++;
				if (coef_q.size() == 0) begin
					report("Unexpected coefficient", '0, out_item);
				end else begin
					exp_it = coef_q.pop_front();
					if (out_item !== exp_it)
						report("Coefficient mismatch", exp_it, out_item);
				end
			end
		end
		errors <= err_cnt;
		pending <= coef_q.size();
		coefs_seen <= coef_cnt;
		sat_seen <= sat_cnt;
	end

endmodule

[tb/tb_svd_back_substitution_top.sv]
// Testbench top: stimulus and verdict for the SVD back-substitution block.
module tb_svd_back_substitution_top;
	import svdbs_pkg::*;

	localparam int CycleLimit = 1000000;
	localparam int RandomItems = 260;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [CfgWidth-1:0] cfg_data;

	int errors, pending, coefs_seen, sat_seen;
	int cycles;
	int item_cnt;
	int compute_cnt;
	bit quiet;
	bit hold_req;
	int rows_eff, cols_eff;
	bit u_wr [16][16];
	bit w_wr [16];
	bit v_wr [16][16];
	bit b_wr [16];

	svd_back_substitution_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	svd_bs_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .coefs_seen(coefs_seen), .sat_seen(sat_seen)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Watchdog on the whole run.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CycleLimit) begin
				$display("tb_svd_back_substitution_top failed");
				$finish;
			end
		end
	end

	// Receiver: random stall bursts, one long hold on request, none when quiet.
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (quiet) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else if (hold_req) begin
				out_stall <= 1'b1;
				repeat (600) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 2) == 0);
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
		end
	end

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 4))
			0: return 32'($urandom_range(0, 4 << 16)) * ($urandom_range(0, 1) ? 1 : -1);
			1: return $urandom();
			2: begin
				case ($urandom_range(0, 4))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					3: return 32'h0000_0001;
					default: return 32'hffff_ffff;
				endcase
			end
			default: return 32'($urandom_range(0, 1 << 20)) - 32'sd524288;
		endcase
	endfunction

	function automatic int clamp_count(int x);
		return (x == 0) ? 1 : ((x > 16) ? 16 : x);
	endfunction

	// Offer one item, with an occasional idle burst first, and wait for acceptance.
	task automatic send_item(in_item_t it);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
		if (it.req_type <= ReqCompute)
			item_cnt++;
	endtask

	task automatic load(logic [2:0] kind, int r, int c, logic signed [31:0] val);
		in_item_t it;
		it.req_type = kind;
		it.row_index = r[3:0];
		it.col_index = c[3:0];
		it.load_value = val;
		send_item(it);
		case (kind)
			ReqLoadU: u_wr[r][c] = 1'b1;
			ReqLoadW: w_wr[r] = 1'b1;
			ReqLoadV: v_wr[r][c] = 1'b1;
			ReqLoadB: b_wr[r] = 1'b1;
			default: ;
		endcase
	endtask

	// Write every element the next compute reads that was never written.
	task automatic fill_missing();
		for (int i = 0; i < cols_eff; i++) begin
			if (!w_wr[i])
				load(ReqLoadW, i, $urandom_range(0, 15), pick_value());
			for (int j = 0; j < cols_eff; j++)
				if (!v_wr[i][j])
					load(ReqLoadV, i, j, pick_value());
		end
		for (int j = 0; j < rows_eff; j++) begin
			if (!b_wr[j])
				load(ReqLoadB, j, $urandom_range(0, 15), pick_value());
			for (int i = 0; i < cols_eff; i++)
				if (!u_wr[j][i])
					load(ReqLoadU, j, i, pick_value());
		end
	endtask

	task automatic compute();
		in_item_t it;
		fill_missing();
		it.req_type = ReqCompute;
		it.row_index = 4'($urandom());
		it.col_index = 4'($urandom());
		it.load_value = $urandom();
		send_item(it);
		compute_cnt++;
	endtask

	// Let the block drain, then write a count register.
	task automatic set_count(logic [0:0] idx, int value);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CfgWidth-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CfgRowCount)
			rows_eff = clamp_count(value & 31);
		else
			cols_eff = clamp_count(value & 31);
	endtask

	task automatic random_round(int round);
		int nloads;
		int kind;
		if ($urandom_range(0, 7) == 0)
			set_count(CfgRowCount, $urandom_range(0, 1) ? 16 : $urandom_range(0, 31));
		else
			set_count(CfgRowCount, $urandom_range(1, 4));
		if ($urandom_range(0, 9) == 0)
			set_count(CfgColCount, $urandom_range(0, 1) ? 0 : 6);
		else if ($urandom_range(0, 3) != 0)
			set_count(CfgColCount, $urandom_range(1, 4));
		nloads = $urandom_range(2, 10);
		for (int k = 0; k < nloads; k++) begin
			kind = $urandom_range(0, 9);
			if (kind > 4) begin
				// Mostly loads inside the active counts.
				kind = $urandom_range(0, 3);
				load(3'(kind), $urandom_range(0, ((kind == ReqLoadU || kind == ReqLoadB) ?
					rows_eff : cols_eff) - 1), $urandom_range(0, cols_eff - 1),
					(kind == ReqLoadW && $urandom_range(0, 3) == 0) ? 32'sd0 : pick_value());
			end else if (kind == 4) begin
				load(3'($urandom_range(5, 7)), $urandom_range(0, 15), $urandom_range(0, 15),
					$urandom());
			end else begin
				load(3'(kind), $urandom_range(0, 15), $urandom_range(0, 15), pick_value());
			end
		end
		if (round == 3)
			hold_req = 1'b1;
		compute();
		// Keep offering loads while the receiver holds off.
		if (round == 3)
			for (int k = 0; k < 6; k++)
				load(ReqLoadB, $urandom_range(0, 15), 0, pick_value());
	endtask

	initial begin
		int round;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet = 1'b0;
		hold_req = 1'b0;
		item_cnt = 0;
		compute_cnt = 0;
		rows_eff = 16;
		cols_eff = 16;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: one by one system with extreme values and a zero singular value.
		set_count(CfgRowCount, 1);
		set_count(CfgColCount, 1);
		load(ReqLoadU, 0, 0, 32'h7fff_ffff);
		load(ReqLoadW, 0, 15, 32'h0000_0001);
		load(ReqLoadV, 0, 0, 32'h7fff_ffff);
		load(ReqLoadB, 0, 15, 32'h7fff_ffff);
		compute();
		load(ReqLoadW, 0, 0, 32'h0000_0000);
		compute();
		load(ReqLoadU, 0, 0, 32'h8000_0000);
		load(ReqLoadB, 0, 0, 32'h8000_0000);
		load(ReqLoadW, 0, 0, 32'hffff_ffff);
		load(ReqLoadV, 0, 0, 32'h8000_0000);
		compute();
		load(ReqLoadW, 0, 0, 32'h0001_0000);
		load(ReqLoadU, 0, 0, 32'h0002_8000);
		load(ReqLoadB, 0, 0, 32'hfffe_0000);
		load(ReqLoadV, 0, 0, 32'h0000_ffff);
		compute();
		// Unused request codes are ignored.
		for (int k = 1; k <= 3; k++)
			load(ReqCompute + 3'(k), 15, 15, 32'hffff_ffff);
		// Zero counts clamp to one.
		set_count(CfgRowCount, 0);
		set_count(CfgColCount, 0);
		compute();
		// All rows, with a row count beyond the maximum clamped to it.
		set_count(CfgRowCount, 31);
		set_count(CfgColCount, 2);
		compute();

		// Random rounds, mostly small systems, until the item budget is used.
		round = 0;
		while (item_cnt < RandomItems) begin
			if (item_cnt > RandomItems - 60)
				quiet = 1'b1;
			random_round(round);
			round++;
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (50) @(posedge clk);
		$display("Covered %0d compute items, %0d coefficients checked, %0d of them saturated.",
			compute_cnt, coefs_seen, sat_seen);
		if (errors == 0 && pending == 0)
			$display("tb_svd_back_substitution_top passed");
		else
			$display("tb_svd_back_substitution_top failed");
		$finish;
	end

endmodule
